FILE: sv/bec_pkg.sv
// Shared types and constants for the back-easing curve block.
package bec_pkg;

  localparam int DEFAULT_FRAC_BITS = 16;

  // Register index decoded from paddr[2]
  localparam logic REG_OVERSHOOT = 1'b0;

  // Overshoot reset 1.70158 as a ratio, scaled to 2^FRAC_BITS at elaboration
  localparam longint OVERSHOOT_NUM = 170158;
  localparam longint OVERSHOOT_DEN = 100000;

  typedef enum logic [1:0] {
    MODE_IN,
    MODE_OUT,
    MODE_IN_OUT,
    MODE_OUT_IN
  } bec_mode_t;

  typedef enum logic [1:0] {
    OFS_NONE,
    OFS_ONE,
    OFS_TWO
  } bec_ofs_t;

  typedef struct packed {
    logic     plus;
    bec_ofs_t ofs;
    logic     halve;
    logic     post_half;
  } bec_ctrl_t;

endpackage

FILE: sv/bec_regs.sv
// Overshoot configuration register with its in-out scaled copy, APB write and read.
module bec_regs #(
  parameter int FRAC_BITS = bec_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic [FRAC_BITS+2:0] overshoot,
  output logic [FRAC_BITS+3:0] overshoot_scaled
);
  import bec_pkg::*;

  localparam int W_S = FRAC_BITS + 3;
  localparam int W_V = FRAC_BITS + 4;
  localparam int W_M = FRAC_BITS + 9;
  localparam int W_Y = W_M - 3;
  localparam int K   = FRAC_BITS + 10;
  localparam int W_R = W_Y + K - 2;

  localparam longint S_RESET_L =
    (OVERSHOOT_NUM * (longint'(1) << FRAC_BITS)) / OVERSHOOT_DEN;
  localparam logic [W_S-1:0] S_RESET  = W_S'(S_RESET_L);
  // s * 1.525 rounded: (1525 s + 500) / 1000 == (61 s + 20) / 40
  localparam logic [W_V-1:0] VS_RESET = W_V'((61 * S_RESET_L + 20) / 40);
  localparam logic [K-3:0]   RECIP5   = (K-2)'(((longint'(1) << K) + 4) / 5);
  localparam logic [W_M-1:0] BIAS     = W_M'(20);

  logic           wr_en;
  logic [W_S-1:0] wr_s;
  logic [W_M-1:0] m61;
  logic [W_Y-1:0] m8;
  logic [W_R-1:0] recip_prod;
  logic [W_V-1:0] scaled_next;

  assign wr_en = psel && penable && pwrite && (paddr[2] == REG_OVERSHOOT);
  assign wr_s  = pwdata[W_S-1:0];

  // 61 s + 20, divide by 8, then by 5 through a reciprocal multiply
  assign m61         = (W_M'(wr_s) << 6) - (W_M'(wr_s) << 2) + W_M'(wr_s) + BIAS;
  assign m8          = m61[W_M-1:3];
  assign recip_prod  = W_R'(m8) * W_R'(RECIP5);
  assign scaled_next = recip_prod[W_R-1:K];

  always_ff @(posedge clk) begin
    if (rst) begin
      overshoot        <= S_RESET;
      overshoot_scaled <= VS_RESET;
    end else if (wr_en) begin
      overshoot        <= wr_s;
      overshoot_scaled <= scaled_next;
    end
  end

  assign prdata = (paddr[2] == REG_OVERSHOOT) ? 32'(overshoot) : 32'd0;

endmodule

FILE: sv/back_easing_curve.sv
// Back-easing curve unit: five-stage pipelined cubic evaluation with overshoot register.
// Stages from input transaction to result: decode, multiply, round, multiply,
//   round/offset/halve/saturate; a stalled output holds its result.
// Throughput: one transaction per cycle unless the output stalls; each stage holds its
//   own valid bit and accepts when empty or when the next stage moves, so bubbles fill.
// Reset (rst, synchronous): clears all valid bits, overshoot returns to 1.70158.
module back_easing_curve #(
  parameter int FRAC_BITS = bec_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // s_axis_tdata: progress
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((FRAC_BITS + 1 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // s_axis_tuser: action
  input  logic [1:0]                             s_axis_tuser,
  // m_axis_tdata: eased_value
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import bec_pkg::*;

  localparam int OUT_TW = ((FRAC_BITS + 2 + 7) / 8) * 8;
  localparam int W_T = FRAC_BITS + 1;
  localparam int W_S = FRAC_BITS + 3;
  localparam int W_V = FRAC_BITS + 4;
  localparam int W_W = FRAC_BITS + 2;
  localparam int W_E = FRAC_BITS + 3;
  localparam int W_P = W_V + 2 + W_W;
  localparam int W_L = W_P + 1;
  localparam int W_A = W_L - FRAC_BITS;
  localparam int W_SQ = 2 * W_W;
  localparam int W_Q = W_SQ - FRAC_BITS;
  localparam int W_PR = W_Q + W_A;
  localparam int W_C = W_PR - FRAC_BITS;
  localparam int W_Y = W_C + 2;
  localparam int N_ST = 5;

  localparam logic        [W_T-1:0]  T_ONE   = W_T'(1) << FRAC_BITS;
  localparam logic        [W_T-1:0]  T_HALF  = W_T'(1) << (FRAC_BITS - 1);
  localparam logic signed [W_E-1:0]  E_ONE   = W_E'(1) << FRAC_BITS;
  localparam logic signed [W_V+1:0]  V_ONE   = (W_V+2)'(1) << FRAC_BITS;
  localparam logic signed [W_L-1:0]  L_HALF  = W_L'(1) << (FRAC_BITS - 1);
  localparam logic signed [W_SQ-1:0] SQ_HALF = W_SQ'(1) << (FRAC_BITS - 1);
  localparam logic signed [W_PR-1:0] PR_HALF = W_PR'(1) << (FRAC_BITS - 1);
  localparam logic signed [W_Y-1:0]  Y_ONE   = W_Y'(1) << FRAC_BITS;
  localparam logic signed [W_Y-1:0]  Y_HALF  = W_Y'(1) << (FRAC_BITS - 1);
  localparam logic signed [W_Y-1:0]  Y_MAX   = (W_Y'(1) << (FRAC_BITS + 1)) - W_Y'(1);
  localparam logic signed [W_Y-1:0]  Y_MIN   = -(W_Y'(1) << (FRAC_BITS + 1));

  logic [W_S-1:0] overshoot;
  logic [W_V-1:0] overshoot_scaled;

  bec_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .overshoot       (overshoot),
    .overshoot_scaled(overshoot_scaled)
  );

  assign pready = 1'b1;

  // Stage valid bits and ready chain
  logic [N_ST-1:0] vld;
  logic [N_ST-1:0] rdy;

  always_comb begin
    rdy[N_ST-1] = !vld[N_ST-1] || m_axis_tready;
    for (int i = N_ST - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < N_ST; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];

  // Stage 1: clamp progress, pick argument, overshoot and offsets
  bec_mode_t              mode_in;
  logic [W_T-1:0]         t_raw;
  logic [W_T-1:0]         t_sat;
  logic signed [W_E-1:0]  t_e;
  logic signed [W_E-1:0]  t2_e;
  logic                   first_half;
  logic signed [W_E-1:0]  w_sel;
  logic [W_V-1:0]         v_next;
  bec_ctrl_t              ctrl_next;

  logic signed [W_W-1:0]  w1;
  logic [W_V-1:0]         v1;
  bec_ctrl_t              ctrl1;

  assign mode_in    = bec_mode_t'(s_axis_tuser);
  assign t_raw      = s_axis_tdata[W_T-1:0];
  assign t_sat      = (t_raw > T_ONE) ? T_ONE : t_raw;
  assign t_e        = signed'(W_E'(t_sat));
  assign t2_e       = t_e <<< 1;
  assign first_half = t_sat < T_HALF;

  always_comb begin
    w_sel     = t_e;
    v_next    = W_V'(overshoot);
    ctrl_next = '{plus: 1'b0, ofs: OFS_NONE, halve: 1'b0, post_half: 1'b0};
    unique case (mode_in)
      MODE_IN: begin
        w_sel = t_e;
      end
      MODE_OUT: begin
        w_sel         = t_e - E_ONE;
        ctrl_next.plus = 1'b1;
        ctrl_next.ofs  = OFS_ONE;
      end
      MODE_IN_OUT: begin
        v_next          = overshoot_scaled;
        ctrl_next.halve = 1'b1;
        if (first_half) begin
          w_sel = t2_e;
        end else begin
          w_sel          = t2_e - (E_ONE <<< 1);
          ctrl_next.plus = 1'b1;
          ctrl_next.ofs  = OFS_TWO;
        end
      end
      MODE_OUT_IN: begin
        w_sel           = t2_e - E_ONE;
        ctrl_next.halve = 1'b1;
        if (first_half) begin
          ctrl_next.plus = 1'b1;
          ctrl_next.ofs  = OFS_ONE;
        end else begin
          ctrl_next.post_half = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && s_axis_tvalid) begin
      w1    <= w_sel[W_W-1:0];
      v1    <= v_next;
      ctrl1 <= ctrl_next;
    end
  end

  // Stage 2: (v + 1) * w and w * w
  logic signed [W_V+1:0]  vp1;
  logic signed [W_P-1:0]  plin2;
  logic signed [W_SQ-1:0] sq2;
  logic [W_V-1:0]         v2;
  bec_ctrl_t              ctrl2;

  assign vp1 = signed'((W_V+2)'(v1)) + V_ONE;

  always_ff @(posedge clk) begin
    if (rdy[1] && vld[0]) begin
      plin2 <= vp1 * w1;
      sq2   <= w1 * w1;
      v2    <= v1;
      ctrl2 <= ctrl1;
    end
  end

  // Stage 3: add or subtract v, round both terms
  logic signed [W_L-1:0]  v_sh;
  logic signed [W_L-1:0]  lin;
  logic signed [W_L-1:0]  lin_rnd;
  logic signed [W_SQ-1:0] sq_rnd;
  logic signed [W_A-1:0]  a3;
  logic signed [W_Q-1:0]  q3;
  bec_ctrl_t              ctrl3;

  assign v_sh    = signed'(W_L'(v2)) <<< FRAC_BITS;
  assign lin     = ctrl2.plus ? (W_L'(plin2) + v_sh) : (W_L'(plin2) - v_sh);
  assign lin_rnd = (lin + L_HALF) >>> FRAC_BITS;
  assign sq_rnd  = (sq2 + SQ_HALF) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rdy[2] && vld[1]) begin
      a3    <= lin_rnd[W_A-1:0];
      q3    <= sq_rnd[W_Q-1:0];
      ctrl3 <= ctrl2;
    end
  end

  // Stage 4: q * a
  logic signed [W_PR-1:0] prod4;
  bec_ctrl_t              ctrl4;

  always_ff @(posedge clk) begin
    if (rdy[3] && vld[2]) begin
      prod4 <= q3 * a3;
      ctrl4 <= ctrl3;
    end
  end

  // Stage 5: round, offset, halve, add one half, saturate
  logic signed [W_PR-1:0] prod_rnd;
  logic signed [W_Y-1:0]  cub;
  logic signed [W_Y-1:0]  ofs_val;
  logic signed [W_Y-1:0]  y_ofs;
  logic signed [W_Y-1:0]  y_half;
  logic signed [W_Y-1:0]  y_fin;
  logic [FRAC_BITS+1:0]   y_sat;
  logic [FRAC_BITS+1:0]   out5;

  assign prod_rnd = (prod4 + PR_HALF) >>> FRAC_BITS;
  assign cub      = W_Y'(signed'(prod_rnd[W_C-1:0]));

  always_comb begin
    case (ctrl4.ofs)
      OFS_ONE: ofs_val = Y_ONE;
      OFS_TWO: ofs_val = Y_ONE <<< 1;
      default: ofs_val = '0;
    endcase
  end

  assign y_ofs  = cub + ofs_val;
  assign y_half = ctrl4.halve ? ((y_ofs + W_Y'(1)) >>> 1) : y_ofs;
  assign y_fin  = ctrl4.post_half ? (y_half + Y_HALF) : y_half;

  always_comb begin
    if (y_fin > Y_MAX) begin
      y_sat = Y_MAX[FRAC_BITS+1:0];
    end else if (y_fin < Y_MIN) begin
      y_sat = Y_MIN[FRAC_BITS+1:0];
    end else begin
      y_sat = y_fin[FRAC_BITS+1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4] && vld[3]) begin
      out5 <= y_sat;
    end
  end

  assign m_axis_tvalid = vld[N_ST-1];
  assign m_axis_tdata  = OUT_TW'(out5);

endmodule

FILE: sv/bec_checker.sv
// Port-level checks for the back-easing curve block, bound to the top level.
module bec_checker #(
  parameter int FRAC_BITS = bec_pkg::DEFAULT_FRAC_BITS
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   s_axis_tready,
  input logic                                   m_axis_tvalid,
  input logic                                   m_axis_tready,
  input logic [((FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input logic                                   psel,
  input logic                                   penable,
  input logic                                   pwrite,
  input logic [2:0]                             paddr,
  input logic [31:0]                            pwdata,
  input logic [31:0]                            prdata,
  input logic                                   pready
);
  import bec_pkg::*;

  localparam int W_S = FRAC_BITS + 3;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_OVERSHOOT);

  // Pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A ready output frees the whole pipe, so input must be ready
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input not ready while output is taken");

  // Read back of the overshoot register after a write
  a_readback: assert property (@(posedge clk) disable iff (rst)
    cfg_wr ##1 (!$past(rst) && psel && !pwrite && paddr[2] == REG_OVERSHOOT)
      |-> prdata == 32'($past(pwdata[W_S-1:0])))
    else $error("overshoot read back mismatch");

endmodule

bind back_easing_curve bec_checker #(.FRAC_BITS(FRAC_BITS)) u_bec_checker (.*);

FILE: test/tb_back_easing_curve.sv
// Testbench for back_easing_curve: streamed curve requests checked against a fixed-point predictor.
`timescale 1ns / 100ps

module tb_back_easing_curve;
  import bec_pkg::*;

  localparam int         FRAC         = DEFAULT_FRAC_BITS;
  localparam int         IN_W         = ((FRAC + 1 + 7) / 8) * 8;
  localparam int         OUT_W        = ((FRAC + 2 + 7) / 8) * 8;
  localparam longint     ONE          = longint'(1) << FRAC;
  localparam longint     OUT_MIN      = -131072;
  localparam longint     OUT_MAX      = 131071;
  localparam logic [18:0] OVS_RESET   = 19'd111514;
  localparam logic [18:0] OVS_MAX     = 19'h7FFFF;
  localparam logic [2:0] OVS_ADDR     = {REG_OVERSHOOT, 2'b00};
  localparam realtime    CLK_PERIOD   = 12.0;
  localparam int         PIPE_LATENCY = 5;
  localparam int         MAX_REPORTS  = 10;

  typedef struct {
    bec_mode_t   mode;
    logic [16:0] progress;
  } ease_point_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;   // [16:0] progress
  logic [1:0]        s_axis_tuser = '0;   // [1:0] action
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;        // [17:0] eased_value
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  ease_point_t          pending_points[$];
  logic signed [17:0]   expected_values[$];
  ease_point_t          point_on_bus;
  logic [18:0]          overshoot_q = OVS_RESET;
  int                   src_idle_pct = 10;
  int                   sink_idle_pct = 65;
  int                   points_queued = 0;
  int                   points_sent = 0;
  int                   values_checked = 0;
  int                   fail_count = 0;
  int                   overshoot_writes = 0;

  back_easing_curve dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic longint round_shift(input longint x, input int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // x^2 * ((v+1)x +/- v), each product rounded back to FRAC bits
  function automatic longint cubic(input longint x, input longint v, input bit plus);
    longint lin;
    longint a;
    longint q;
    lin = (v + ONE) * x + (plus ? v * ONE : -(v * ONE));
    a   = round_shift(lin, FRAC);
    q   = round_shift(x * x, FRAC);
    return round_shift(q * a, FRAC);
  endfunction

  function automatic logic signed [17:0] back_ease(input bec_mode_t mode,
                                                   input logic [16:0] progress,
                                                   input logic [18:0] overshoot);
    longint t;
    longint s;
    longint v;
    longint y;
    t = (progress > ONE) ? ONE : longint'(progress);
    s = longint'(overshoot);
    case (mode)
      MODE_IN: begin
        y = cubic(t, s, 1'b0);
      end
      MODE_OUT: begin
        y = cubic(t - ONE, s, 1'b1) + ONE;
      end
      MODE_IN_OUT: begin
        v = (s * 1525 + 500) / 1000;
        if (2 * t < ONE) begin
          y = round_shift(cubic(2 * t, v, 1'b0), 1);
        end else begin
          y = round_shift(cubic(2 * t - 2 * ONE, v, 1'b1) + 2 * ONE, 1);
        end
      end
      default: begin
        if (2 * t < ONE) begin
          y = round_shift(cubic(2 * t - ONE, s, 1'b1) + ONE, 1);
        end else begin
          y = round_shift(cubic(2 * t - ONE, s, 1'b0), 1) + ONE / 2;
        end
      end
    endcase
    if (y < OUT_MIN) y = OUT_MIN;
    if (y > OUT_MAX) y = OUT_MAX;
    return 18'(y);
  endfunction

  // driver: a transaction completes on tvalid && tready at the edge
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_values.push_back(back_ease(point_on_bus.mode, point_on_bus.progress,
                                            overshoot_q));
        points_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          point_on_bus  = pending_points.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_W'(point_on_bus.progress);
          s_axis_tuser  <= point_on_bus.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic signed [17:0] got;
    logic signed [17:0] want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[17:0];
        if (expected_values.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: unexpected result eased_value=%0d", $realtime, got);
          fail_count++;
        end else begin
          want = expected_values.pop_front();
          values_checked++;
          if (got !== want) begin
            if (fail_count < MAX_REPORTS)
              $display("%0t: eased_value mismatch: expected %0d, got %0d",
                       $realtime, want, got);
            fail_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic queue_point(input bec_mode_t mode, input logic [16:0] progress);
    ease_point_t p;
    p.mode     = mode;
    p.progress = progress;
    pending_points.push_back(p);
    points_queued++;
  endtask

  // end points, the half split, and progress beyond one, for every mode
  task automatic queue_directed();
    logic [16:0] corners[6];
    corners = '{17'd0, 17'd32767, 17'd32768, 17'd65535, 17'd65536, 17'd131071};
    for (int m = 0; m < 4; m++) begin
      foreach (corners[i]) queue_point(bec_mode_t'(m), corners[i]);
    end
  endtask

  task automatic queue_random(input int count);
    logic [16:0] t;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0:       t = 17'($urandom_range(131071, 65537));
        1:       t = 17'($urandom_range(32776, 32760));
        2:       t = $urandom_range(1) ? 17'd0 : 17'(ONE);
        default: t = 17'($urandom_range(65536));
      endcase
      queue_point(bec_mode_t'($urandom_range(3)), t);
    end
  endtask

  task automatic wait_drained();
    while (points_sent != points_queued || expected_values.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
  endtask

  // write the overshoot register, then read it back
  task automatic set_overshoot(input logic [18:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= OVS_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    overshoot_q = value;
    overshoot_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== 32'(value)) begin
      if (fail_count < MAX_REPORTS)
        $display("%0t: overshoot readback: expected %0d, got %0d", $realtime, value, prdata);
      fail_count++;
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_idle_pct  = 10;
    sink_idle_pct = 65;
    queue_directed();
    queue_random(450);
    wait_drained();

    set_overshoot(19'd0);
    queue_random(350);
    wait_drained();

    src_idle_pct  = 65;
    sink_idle_pct = 10;
    set_overshoot(OVS_MAX);
    queue_directed();
    queue_random(350);
    wait_drained();

    set_overshoot(19'($urandom_range(524286, 1)));
    queue_random(300);
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_overshoot(OVS_RESET);
    queue_random(350);
    wait_drained();

    if (expected_values.size() != 0) begin
      $display("%0d expected results never arrived", expected_values.size());
      fail_count++;
    end
    $display("Sent %0d curve transactions across all four modes under %0d overshoot writes,",
             points_sent, overshoot_writes);
    $display("including zero and full-scale overshoot; %0d results checked, %0d failures.",
             values_checked, fail_count);
    if (fail_count == 0) begin
      $display("tb_back_easing_curve: PASS");
    end else begin
      $display("tb_back_easing_curve: FAIL");
    end
    $finish;
  end

  initial begin
    #(200000 * CLK_PERIOD);
    $display("Timeout with %0d results still expected", expected_values.size());
    $display("tb_back_easing_curve: FAIL");
    $finish;
  end

endmodule
